// ----- design/wrmap_pkg.sv -----
// ----------------------------------------------------------------------------
// wrmap_pkg
// Shared widths, register indexes, window layout and match bundle for the
// windowed register map.
// ----------------------------------------------------------------------------
package wrmap_pkg;

  localparam int NUM_WINDOWS = 4;   // 1 .. 4
  localparam int STORE_DEPTH = 64;  // power of two, 2 .. 64

  localparam int IDX_W     = $clog2(STORE_DEPTH);
  localparam int ADDR_W    = 16;
  localparam int DATA_W    = 16;
  localparam int BASE_W    = 6;
  localparam int CNT_W     = 3;
  localparam int CFG_W     = 39;
  localparam int CFG_IDX_W = 3;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  // Register indexes; windows follow on from REG_WINDOW_FIRST.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_COUNT = 3'd0,
    REG_WINDOW_FIRST = 3'd1
  } cfg_reg_e;

  typedef struct packed {
    logic              writable;
    logic [BASE_W-1:0] base;
    logic [ADDR_W-1:0] finish;
    logic [ADDR_W-1:0] start;
  } window_t;

  // Per-window decode of the held address.
  typedef struct packed {
    logic [NUM_WINDOWS-1:0]            hit;
    logic [NUM_WINDOWS-1:0]            wr;
    logic [NUM_WINDOWS-1:0][IDX_W-1:0] idx;
  } win_match_t;

endpackage

// ----- design/wrmap_windows.sv -----
// ----------------------------------------------------------------------------
// wrmap_windows
// Window configuration registers and the parallel address compare per window.
// ----------------------------------------------------------------------------
module wrmap_windows
  import wrmap_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic [ADDR_W-1:0]    addr_i,
  output win_match_t           match_o
);

  logic [CNT_W-1:0] count_q;
  window_t          win_q [NUM_WINDOWS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int i = 0; i < NUM_WINDOWS; i++) begin
        win_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_WINDOW_COUNT) begin
        count_q <= cfg_wdata_i[CNT_W-1:0];
      end
      for (int i = 0; i < NUM_WINDOWS; i++) begin
        if (cfg_index_i == CFG_IDX_W'(REG_WINDOW_FIRST) + CFG_IDX_W'(i)) begin
          win_q[i] <= window_t'(cfg_wdata_i);
        end
      end
    end
  end

  // A count above NUM_WINDOWS simply enables every window.
  always_comb begin
    logic [ADDR_W-1:0] off;
    match_o = '0;
    for (int i = 0; i < NUM_WINDOWS; i++) begin
      off             = addr_i - win_q[i].start;
      match_o.hit[i]  = (count_q > CNT_W'(i)) &&
                        (addr_i >= win_q[i].start) && (addr_i <= win_q[i].finish);
      match_o.wr[i]   = match_o.hit[i] && win_q[i].writable;
      match_o.idx[i]  = IDX_W'(ADDR_W'(win_q[i].base) + off);
    end
  end

endmodule

// ----- design/wrmap_store.sv -----
// ----------------------------------------------------------------------------
// wrmap_store
// Shared word store: one write and one registered read per cycle, with a
// per-word valid bit so every word reads as zero until first written.
// ----------------------------------------------------------------------------
module wrmap_store
  import wrmap_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [IDX_W-1:0]  waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [IDX_W-1:0]  raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0]      mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] vld_q;
  logic [DATA_W-1:0]      rd_q;
  logic                   rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_vld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

// ----- design/windowed_register_map_core.sv -----
// ----------------------------------------------------------------------------
// windowed_register_map_core
// Register map over up to four address windows sharing one word store.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------------------
//  in      | in        | in_valid_i/in_stall_o | opcode_i, reg_address_i,
//          |           |                       | write_data_i
//  out     | out       | out_valid_o/out_stall_i | read_data_o (reads only)
//  cfg     | in        | cfg_we_i              | cfg_index_i, cfg_wdata_i
//
// One word per cycle while the input is not stalled. A write that hits several writable
// windows holds the access register while it writes them one at a time, lowest first,
// as the store has one write port. A read gives its word through the store's
// registered read port, which doubles as the output register, once that is free.
// Reset clears the per-word valid bits at once; no clearing pass is needed.
// A stalled output holds its word; the access register keeps taking words
// behind it until a second read needs the output register.
// ----------------------------------------------------------------------------
module windowed_register_map_core
  import wrmap_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  // access words
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 opcode_i,
  input  logic [ADDR_W-1:0]    reg_address_i,
  input  logic [DATA_W-1:0]    write_data_i,
  // read results
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [DATA_W-1:0]    read_data_o
);

  // Access register
  logic                   s1_valid_q, s1_valid_d;
  op_e                    s1_op_q;
  logic [ADDR_W-1:0]      s1_addr_q;
  logic [DATA_W-1:0]      s1_data_q;
  logic [NUM_WINDOWS-1:0] s1_done_q, s1_done_d;   // windows already written

  // Output register control
  logic                   out_valid_q, out_valid_d;
  logic                   out_miss_q;

  win_match_t             match;
  logic [NUM_WINDOWS-1:0] remaining, pick, first_hit;
  logic [IDX_W-1:0]       widx, ridx;
  logic                   more, any_hit, out_free, s1_fire, in_acc;
  logic                   st_we, st_re;
  logic [DATA_W-1:0]      st_rdata;

  wrmap_windows u_windows (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .addr_i      (s1_addr_q),
    .match_o     (match)
  );

  // Writes walk the writable hits lowest first, one per cycle; a read uses
  // the lowest hit of any kind.
  always_comb begin
    remaining = match.wr & ~s1_done_q;
    pick      = remaining & (~remaining + NUM_WINDOWS'(1));
    more      = |(remaining & ~pick);
    first_hit = match.hit & (~match.hit + NUM_WINDOWS'(1));
    any_hit   = |match.hit;
    widx      = '0;
    ridx      = '0;
    for (int i = 0; i < NUM_WINDOWS; i++) begin
      if (pick[i]) begin
        widx = match.idx[i];
      end
      if (first_hit[i]) begin
        ridx = match.idx[i];
      end
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && ((s1_op_q == OP_WRITE) ? !more : out_free);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign st_we = s1_valid_q && (s1_op_q == OP_WRITE) && (|remaining);
  assign st_re = s1_fire && (s1_op_q == OP_READ);

  wrmap_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (st_we),
    .waddr_i (widx),
    .wdata_i (s1_data_q),
    .re_i    (st_re),
    .raddr_i (ridx),
    .rdata_o (st_rdata)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_done_d  = s1_done_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
      s1_done_d  = '0;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
      s1_done_d  = '0;
    end else if (st_we) begin
      s1_done_d  = s1_done_q | pick;
    end

    out_valid_d = out_valid_q;
    if (st_re) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_done_q   <= '0;
      out_valid_q <= 1'b0;
      out_miss_q  <= 1'b1;
    end else begin
      s1_valid_q  <= s1_valid_d;
      s1_done_q   <= s1_done_d;
      out_valid_q <= out_valid_d;
      if (st_re) begin
        out_miss_q <= !any_hit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q   <= op_e'(opcode_i);
      s1_addr_q <= reg_address_i;
      s1_data_q <= write_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_miss_q ? '0 : st_rdata;

endmodule

// ----- design/wrmap_chk.sv -----
// ----------------------------------------------------------------------------
// wrmap_chk
// Port-level checks for the windowed register map, bound to the top level.
// ----------------------------------------------------------------------------
module wrmap_chk
  import wrmap_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              opcode_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [DATA_W-1:0] read_data_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_data_o))
    else $error("result word changed while stalled");

  // an accepted read reaches the output when the output register is free for it
  a_read_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && opcode_i == OP_READ) ##1 (!out_valid_o || !out_stall_i)
      |=> out_valid_o)
    else $error("accepted read gave no result word");

  // a write never produces a result word
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && opcode_i == OP_WRITE) ##1 !out_valid_o |=> !out_valid_o)
    else $error("write produced a result word");

  // with the output empty, only a write walking its windows holds the input,
  // and that frees up once the write has covered all its windows
  a_write_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && !out_valid_o |-> ##[1:NUM_WINDOWS] !in_stall_o)
    else $error("input stalled too long with the output empty");

endmodule

bind windowed_register_map_core wrmap_chk u_wrmap_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .opcode_i    (opcode_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .read_data_o (read_data_o)
);
